>>> hw/rtl/rpst_pkg.sv
// Shared sign codes, request modes, helper functions and control structs.
package rpst_pkg;

   localparam int INDEX_W = 10;
   localparam int VALUE_W = 16;
   localparam int SIGN_W  = 2;

   localparam logic [SIGN_W-1:0] SIGN_ZERO = 2'd0;
   localparam logic [SIGN_W-1:0] SIGN_POS  = 2'd1;
   localparam logic [SIGN_W-1:0] SIGN_NEG  = 2'd2;

   localparam logic MODE_SET   = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clr_step;
      logic load_set;
      logic set_step;
      logic load_query;
      logic q_left;
      logic q_right;
      logic rsp_load;
   } rpst_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clr_last;
      logic set_ok;
      logic k_root;
      logic l_lt_r;
      logic rsp_free;
   } rpst_status_type;

   function automatic logic [SIGN_W-1:0] sign_mul(input logic [SIGN_W-1:0] x,
                                                  input logic [SIGN_W-1:0] y);
      logic [SIGN_W-1:0] res;
      if (x == SIGN_ZERO || y == SIGN_ZERO) begin
         res = SIGN_ZERO;
      end else if (x == y) begin
         res = SIGN_POS;
      end else begin
         res = SIGN_NEG;
      end
      return res;
   endfunction

   function automatic logic [SIGN_W-1:0] sign_of(input logic signed [VALUE_W-1:0] v);
      logic [SIGN_W-1:0] res;
      if (v == '0) begin
         res = SIGN_ZERO;
      end else if (v[VALUE_W-1]) begin
         res = SIGN_NEG;
      end else begin
         res = SIGN_POS;
      end
      return res;
   endfunction

endpackage

>>> hw/rtl/rpst_ctrl.sv
// Sequencer for clearing, element updates and range queries.
module rpst_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_mode,
   input  rpst_pkg::rpst_status_type status,
   output rpst_pkg::rpst_cmd_type    cmd,
   output logic                     req_stall
);
   import rpst_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SET_UP,
      ST_Q_LEFT,
      ST_Q_RIGHT,
      ST_Q_DONE,
      ST_Q_OUT
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_mode == MODE_QUERY) begin
                  cmd.load_query = 1'b1;
                  state_in       = ST_Q_LEFT;
               end else if (status.set_ok) begin
                  cmd.load_set = 1'b1;
                  state_in     = ST_SET_UP;
               end
            end
         end
         ST_SET_UP: begin
            cmd.set_step = 1'b1;
            if (status.k_root) state_in = ST_IDLE;
         end
         ST_Q_LEFT: begin
            if (status.l_lt_r) begin
               cmd.q_left = 1'b1;
               state_in   = ST_Q_RIGHT;
            end else begin
               state_in = ST_Q_DONE;
            end
         end
         ST_Q_RIGHT: begin
            cmd.q_right = 1'b1;
            state_in    = ST_Q_LEFT;
         end
         ST_Q_DONE: begin
            // The accumulator already holds the last node read; this is a spare cycle.
            state_in = ST_Q_OUT;
         end
         ST_Q_OUT: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

endmodule

>>> hw/rtl/rpst_datapath.sv
// Node memory, walk registers, sign accumulator and result register.
module rpst_datapath #(
   parameter int ELEMENTS = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rpst_pkg::rpst_cmd_type               cmd,
   output rpst_pkg::rpst_status_type            status,
   input  logic [rpst_pkg::INDEX_W-1:0]         req_index_lo,
   input  logic [rpst_pkg::INDEX_W-1:0]         req_index_hi,
   input  logic signed [rpst_pkg::VALUE_W-1:0]  req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [rpst_pkg::SIGN_W-1:0]          rsp_sign_code
);
   import rpst_pkg::*;

   localparam int NODES = 2 * ELEMENTS;
   localparam int AW    = $clog2(NODES);
   localparam int CW    = AW + 1;
   localparam int EW    = ((CW > INDEX_W) ? CW : INDEX_W) + 1;

   logic [SIGN_W-1:0] mem [NODES];
   logic [SIGN_W-1:0] rd_data_ff;

   logic [AW-1:0]     clr_cnt_ff, clr_cnt_in;
   logic [CW-1:0]     k_ff, k_in;
   logic [CW-1:0]     l_ff, l_in;
   logic [CW-1:0]     r_ff, r_in;
   logic [SIGN_W-1:0] cur_ff, cur_in;
   logic [SIGN_W-1:0] acc_ff, acc_in;
   logic              pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SIGN_W-1:0] rsp_sign_ff, rsp_sign_in;

   logic              wr_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [SIGN_W-1:0] wr_data;

   logic [EW-1:0]     lo_ext, hi_ext, hi_clamp, n_ext;
   logic [CW-1:0]     leaf, q_l, q_r, r_dec;
   logic              empty;
   logic [SIGN_W-1:0] par;

   assign n_ext    = EW'(ELEMENTS);
   assign lo_ext   = EW'(req_index_lo);
   assign hi_ext   = EW'(req_index_hi);
   assign hi_clamp = (hi_ext >= n_ext) ? (n_ext - EW'(1)) : hi_ext;
   assign empty    = (lo_ext > hi_clamp);
   assign leaf     = CW'(lo_ext + n_ext);
   assign q_l      = leaf;
   assign q_r      = CW'(hi_clamp + n_ext + EW'(1));
   assign r_dec    = r_ff - CW'(1);
   assign par      = sign_mul(cur_ff, rd_data_ff);

   assign status.clr_last = &clr_cnt_ff;
   assign status.set_ok   = (lo_ext < n_ext);
   assign status.k_root   = (k_ff == CW'(1));
   assign status.l_lt_r   = (l_ff < r_ff);
   assign status.rsp_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_sign_code = rsp_sign_ff;

   always_comb begin
      clr_cnt_in   = clr_cnt_ff;
      k_in         = k_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      cur_in       = cur_ff;
      pend_in      = 1'b0;
      acc_in       = pend_ff ? sign_mul(acc_ff, rd_data_ff) : acc_ff;
      wr_en        = 1'b0;
      wr_addr      = leaf[AW-1:0];
      wr_data      = SIGN_POS;
      rd_addr      = l_ff[AW-1:0];
      rsp_sign_in  = rsp_sign_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (cmd.clr_step) begin
         wr_en      = 1'b1;
         wr_addr    = clr_cnt_ff;
         wr_data    = SIGN_POS;
         clr_cnt_in = clr_cnt_ff + AW'(1);
      end
      if (cmd.load_set) begin
         // Leaf gets the new sign; its sibling is fetched for the parent.
         wr_en   = 1'b1;
         wr_addr = leaf[AW-1:0];
         wr_data = sign_of(req_value);
         cur_in  = sign_of(req_value);
         rd_addr = leaf[AW-1:0] ^ AW'(1);
         k_in    = leaf >> 1;
      end
      if (cmd.set_step) begin
         wr_en   = 1'b1;
         wr_addr = k_ff[AW-1:0];
         wr_data = par;
         cur_in  = par;
         rd_addr = k_ff[AW-1:0] ^ AW'(1);
         k_in    = k_ff >> 1;
      end
      if (cmd.load_query) begin
         l_in   = empty ? '0 : q_l;
         r_in   = empty ? '0 : q_r;
         acc_in = SIGN_POS;
      end
      if (cmd.q_left && l_ff[0]) begin
         rd_addr = l_ff[AW-1:0];
         pend_in = 1'b1;
         l_in    = l_ff + CW'(1);
      end
      if (cmd.q_right) begin
         if (r_ff[0]) begin
            rd_addr = r_dec[AW-1:0];
            pend_in = 1'b1;
         end
         l_in = l_ff >> 1;
         r_in = r_ff >> 1;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_sign_in  = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_cnt_ff   <= clr_cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff        <= k_in;
      l_ff        <= l_in;
      r_ff        <= r_in;
      cur_ff      <= cur_in;
      acc_ff      <= acc_in;
      rsp_sign_ff <= rsp_sign_in;
   end

   // A new result never overwrites a word that is still waiting.
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while stalled");

   // The update walk never climbs past the root.
   a_set_above_root: assert property (@(posedge clock) disable iff (reset)
      cmd.set_step |-> (k_ff != '0))
      else $error("update walk reached node zero");

   // Query bounds stay ordered and inside the tree.
   a_query_bounds: assert property (@(posedge clock) disable iff (reset)
      cmd.q_right |-> (l_ff <= r_ff && r_ff <= CW'(NODES)))
      else $error("query bounds out of order");

endmodule

>>> hw/rtl/range_product_sign_tree_unit.sv
// A set word writes the node memory once per level, from the leaf up to the root.
// A query reads at most two nodes per level on its way to the result.
// Words are handled one at a time; req_stall stays high until the word is finished.
// A waiting result sits in an output register, so the next request is taken meanwhile.
// After reset a clearing pass writes every node positive, with req_stall high.
module range_product_sign_tree_unit #(
   parameter int ELEMENTS = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_mode,
   input  logic [rpst_pkg::INDEX_W-1:0]         req_index_lo,
   input  logic [rpst_pkg::INDEX_W-1:0]         req_index_hi,
   input  logic signed [rpst_pkg::VALUE_W-1:0]  req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [rpst_pkg::SIGN_W-1:0]          rsp_sign_code
);
   import rpst_pkg::*;

   rpst_cmd_type    cmd;
   rpst_status_type status;

   rpst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   rpst_datapath #(
      .ELEMENTS (ELEMENTS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_index_lo  (req_index_lo),
      .req_index_hi  (req_index_hi),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_sign_code (rsp_sign_code)
   );

endmodule
